FILE: rtl/bitvector_rw_lock_resolver_defines.svh
// Assertion macros for the reader-writer lock resolver.
`ifndef BITVECTOR_RW_LOCK_RESOLVER_DEFINES_SVH
`define BITVECTOR_RW_LOCK_RESOLVER_DEFINES_SVH

`ifndef SYNTH

`define BVRW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define BVRW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`define BVRW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define BVRW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define BVRW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`define BVRW_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: rtl/bvrw_pkg.sv
// Types, codes and helper functions shared by the lock resolver modules.
package bvrw_pkg;

    localparam int OBJ_W   = 10;
    localparam int HALF_W  = 32;
    localparam int WORD_W  = 64;
    localparam int POS_W   = 5;
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] MAX_GRANTS = 6'd32;

    localparam logic [1:0] FUNC_LOCK   = 2'd0;
    localparam logic [1:0] FUNC_UNLOCK = 2'd1;
    localparam logic [1:0] FUNC_REREAD = 2'd2;

    localparam logic [2:0] KIND_LOCK_OK   = 3'd0;
    localparam logic [2:0] KIND_QUEUED    = 3'd1;
    localparam logic [2:0] KIND_QUEUE_OK  = 3'd2;
    localparam logic [2:0] KIND_UNLOCK_OK = 3'd3;
    localparam logic [2:0] KIND_GRANT     = 3'd4;

    localparam logic [1:0] CFG_OWNER_BIT = 2'd0;
    localparam logic [1:0] CFG_OWNER_ID  = 2'd1;
    localparam logic [1:0] CFG_MGR_ID    = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [OBJ_W-1:0]  obj_idx;
        logic              lk_type;
        logic [WORD_W-1:0] lock_word;
        logic [3:0]        rel_node;
        logic [31:0]       seq_no;
        logic [31:0]       user_id;
        logic [15:0]       cont_cnt;
        logic              undo;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       kind;
        logic [31:0]      res_seq_no;
        logic [31:0]      res_user_id;
        logic [OBJ_W-1:0] res_obj_idx;
        logic             res_lk_type;
        logic [15:0]      res_contention;
        logic [3:0]       grant_node;
        logic [7:0]       res_owner_id;
        logic [7:0]       res_mgr_id;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic             grant_vld;
        logic             done;
        logic             gtype;
        logic [POS_W-1:0] node;
    } t_scan_stat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_RMW,
        ST_GRANT
    } t_state;

    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = v[8*(7-i) +: 8];
        end
        return r;
    endfunction

    function automatic t_out_item make_result(
        input logic [2:0]       kind,
        input logic [31:0]      seq,
        input logic [31:0]      user,
        input logic [OBJ_W-1:0] obj,
        input logic             ltype,
        input logic [15:0]      cont,
        input logic [3:0]       node,
        input logic [7:0]       own,
        input logic [7:0]       mgr,
        input logic             last
    );
        t_out_item r;
        r.kind           = kind;
        r.res_seq_no     = seq;
        r.res_user_id    = user;
        r.res_obj_idx    = obj;
        r.res_lk_type    = ltype;
        r.res_contention = cont;
        r.grant_node     = node;
        r.res_owner_id   = own;
        r.res_mgr_id     = mgr;
        r.last           = last;
        return r;
    endfunction

endpackage

FILE: rtl/bvrw_mem.sv
// Waiter table storage: one write port, one registered read port.
module bvrw_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [bvrw_pkg::WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [bvrw_pkg::WORD_W-1:0] o_rdata
);
    import bvrw_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bvrw_slot.sv
// Object index to table slot reduction (index modulo table depth).
module bvrw_slot #(
    parameter  int OBJECTS = 1024,
    localparam int SLOT_W  = (OBJECTS > 1) ? $clog2(OBJECTS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [bvrw_pkg::OBJ_W-1:0] i_obj,
    output logic [SLOT_W-1:0]          o_slot
);
    import bvrw_pkg::*;

    localparam int RSH    = 20;
    localparam int RCP_W  = RSH + 1;
    localparam int PROD_W = RCP_W + OBJ_W;
    localparam int QD_W   = OBJ_W + 17;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RSH) / OBJECTS);

    logic [OBJ_W-1:0]  r_obj;
    logic [OBJ_W-1:0]  r_q;
    logic [PROD_W-1:0] w_prod;
    logic [QD_W-1:0]   w_qd;
    logic [QD_W-1:0]   w_diff;
    logic [OBJ_W-1:0]  w_r;
    logic [OBJ_W-1:0]  w_fix;

    // quotient estimate, low by at most one
    assign w_prod = PROD_W'(i_obj) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_obj <= i_obj;
            r_q   <= w_prod[RSH +: OBJ_W];
        end
    end

    assign w_qd   = QD_W'(r_q) * QD_W'(OBJECTS);
    assign w_diff = QD_W'(r_obj) - w_qd;
    assign w_r    = w_diff[OBJ_W-1:0];
    assign w_fix  = (17'(w_r) >= 17'(OBJECTS)) ? (w_r - OBJ_W'(OBJECTS)) : w_r;
    assign o_slot = SLOT_W'(w_fix);

endmodule

FILE: rtl/bvrw_scan.sv
// Grant sequencer: walks waiting node bits, one grant per transfer.
`include "bitvector_rw_lock_resolver_defines.svh"

module bvrw_scan #(
    parameter int NODES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_type,
    input  logic [bvrw_pkg::HALF_W-1:0] i_sh_bits,
    input  logic [bvrw_pkg::HALF_W-1:0] i_ex_bits,
    input  logic                        i_step,
    output bvrw_pkg::t_scan_stat        o_stat
);
    import bvrw_pkg::*;

    logic [NODES-1:0] r_mask, n_mask;
    logic [NODES-1:0] r_next, n_next;
    logic             r_two, n_two;
    logic             r_gtype, n_gtype;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0] w_pos;
    logic             w_done;

    always_comb begin
        w_pos = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_pos = POS_W'(i);
            end
        end
    end

    assign w_done = (r_cnt == MAX_GRANTS) || ((r_mask == '0) && !r_two);

    assign o_stat.grant_vld = !w_done && (r_mask != '0);
    assign o_stat.done      = w_done;
    assign o_stat.gtype     = r_gtype;
    assign o_stat.node      = w_pos;

    always_comb begin
        n_mask  = r_mask;
        n_next  = r_next;
        n_two   = r_two;
        n_gtype = r_gtype;
        n_cnt   = r_cnt;
        priority if (i_start) begin
            // exclusive unlock: shared waiters first, then exclusive
            n_mask  = i_type ? i_sh_bits[NODES-1:0] : i_ex_bits[NODES-1:0];
            n_next  = i_ex_bits[NODES-1:0];
            n_two   = i_type;
            n_gtype = ~i_type;
            n_cnt   = '0;
        end else if ((r_mask == '0) && r_two) begin
            n_mask  = r_next;
            n_two   = 1'b0;
            n_gtype = 1'b1;
        end else if (i_step) begin
            n_mask = r_mask & (r_mask - NODES'(1));
            n_cnt  = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_two   <= 1'b0;
            r_gtype <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_mask  <= n_mask;
            r_two   <= n_two;
            r_gtype <= n_gtype;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next <= n_next;
    end

    `BVRW_ASSERT_IMP(a_step_on_grant, i_clk, i_rst_n, i_step && !i_start, o_stat.grant_vld)
    `BVRW_ASSERT_NEVER(a_cnt_cap, i_clk, i_rst_n, r_cnt > MAX_GRANTS)
    `BVRW_ASSERT_NXT(a_start_clears, i_clk, i_rst_n, i_start, r_cnt == '0)

endmodule

FILE: rtl/bitvector_rw_lock_resolver.sv
// Reader-writer lock word resolver: top level, control sequencer and config.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------
//   in      | to block  | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//   out     | from block| o_out_valid / i_out_ready| o_out_data (t_out_item)
//   cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item at a time. Reread reads the table, then writes it back. Unlock
// emits one grant transfer per waiting node, then its final result. Undo and
// unused codes return to idle without a result.
// After reset a clearing pass writes zero to all OBJECTS table entries,
// one per cycle; o_in_ready stays low until it ends. Config is always ready.
// A stalled output holds the sequencer in place.
`include "bitvector_rw_lock_resolver_defines.svh"

module bitvector_rw_lock_resolver #(
    parameter int OBJECTS = 1024,
    parameter int NODES   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bvrw_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bvrw_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import bvrw_pkg::*;

    localparam int SLOT_W = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(OBJECTS - 1);

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_clr_addr, n_clr_addr;
    t_in_item          r_item;
    logic [31:0]       r_owner_bit;
    logic [7:0]        r_owner_id;
    logic [7:0]        r_mgr_id;
    t_out_item         r_out;
    logic              r_out_vld;

    logic              w_accept;
    logic              w_out_free;
    logic              w_emit;
    t_out_item         w_res;
    logic [SLOT_W-1:0] w_slot;
    logic              w_mem_we;
    logic [SLOT_W-1:0] w_mem_waddr;
    logic [WORD_W-1:0] w_mem_wdata;
    logic [WORD_W-1:0] w_rdata;
    logic              w_scan_start;
    logic              w_scan_step;
    t_scan_stat        w_scan;

    logic [WORD_W-1:0] w_swap;
    logic [HALF_W-1:0] w_ex;
    logic [HALF_W-1:0] w_sh;
    logic [HALF_W-1:0] w_ex_adj;
    logic [HALF_W-1:0] w_sh_adj;
    logic              w_lock_ok;
    logic [15:0]       w_cont_inc;
    logic              w_rel_hit;
    logic [WORD_W-1:0] w_clr;
    logic [WORD_W-1:0] w_new_w;
    logic [WORD_W-1:0] w_rem;
    logic              w_rr_ok;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    bvrw_slot #(.OBJECTS(OBJECTS)) u_slot (
        .i_clk  (i_clk),
        .i_load (w_accept),
        .i_obj  (i_in_data.obj_idx),
        .o_slot (w_slot)
    );

    bvrw_mem #(.DEPTH(OBJECTS), .AW(SLOT_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_slot),
        .o_rdata (w_rdata)
    );

    bvrw_scan #(.NODES(NODES)) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_scan_start),
        .i_type    (r_item.lk_type),
        .i_sh_bits (w_sh_adj),
        .i_ex_bits (w_ex_adj),
        .i_step    (w_scan_step),
        .o_stat    (w_scan)
    );

    // datapath
    assign w_swap     = swap_bytes(r_item.lock_word);
    assign w_ex       = w_swap[WORD_W-1:HALF_W];
    assign w_sh       = w_swap[HALF_W-1:0];
    assign w_ex_adj   = r_item.lk_type ? (w_ex - r_owner_bit) : w_ex;
    assign w_sh_adj   = r_item.lk_type ? w_sh : (w_sh - r_owner_bit);
    assign w_lock_ok  = r_item.lk_type ? (w_swap == '0) : (w_ex == '0);
    assign w_cont_inc = (r_item.cont_cnt == 16'hFFFF) ? r_item.cont_cnt
                                                      : r_item.cont_cnt + 16'd1;
    assign w_rel_hit  = (32'(r_item.rel_node) < NODES);
    assign w_clr      = w_rel_hit ? ((WORD_W'(1) << r_item.rel_node)
                                    | (WORD_W'(1) << (HALF_W + 32'(r_item.rel_node))))
                                  : '0;
    assign w_new_w    = w_rdata & ~w_clr;
    assign w_rem      = r_item.lock_word & w_new_w;
    assign w_rr_ok    = (w_rem == '0)
                     || ((w_rem[WORD_W-1:HALF_W] == '0) && !r_item.lk_type);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        w_mem_we     = 1'b0;
        w_mem_waddr  = w_slot;
        w_mem_wdata  = w_swap;
        w_emit       = 1'b0;
        w_scan_start = 1'b0;
        w_scan_step  = 1'b0;
        w_res        = make_result(KIND_UNLOCK_OK, r_item.seq_no, r_item.user_id,
                                   r_item.obj_idx, r_item.lk_type,
                                   r_item.cont_cnt, 4'd0, 8'd0,
                                   r_mgr_id, 1'b1);
        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                w_mem_wdata = '0;
                n_clr_addr  = r_clr_addr + SLOT_W'(1);
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                unique case (r_item.func)
                    FUNC_LOCK: begin
                        if (w_lock_ok) begin
                            w_res = make_result(KIND_LOCK_OK, r_item.seq_no, r_item.user_id,
                                                r_item.obj_idx, r_item.lk_type,
                                                r_item.cont_cnt, 4'd0, 8'd0,
                                                r_mgr_id, 1'b1);
                        end else begin
                            w_res = make_result(KIND_QUEUED, r_item.seq_no, r_item.user_id,
                                                r_item.obj_idx, r_item.lk_type,
                                                w_cont_inc, 4'd0, 8'd0,
                                                r_mgr_id, 1'b1);
                        end
                        if (w_out_free) begin
                            w_emit   = 1'b1;
                            w_mem_we = !w_lock_ok;
                            n_state  = ST_IDLE;
                        end
                    end
                    FUNC_UNLOCK: begin
                        if (r_item.undo) begin
                            n_state = ST_IDLE;
                        end else begin
                            w_scan_start = 1'b1;
                            n_state      = ST_GRANT;
                        end
                    end
                    FUNC_REREAD: begin
                        n_state = ST_RMW;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_RMW: begin
                w_mem_wdata = w_new_w;
                w_res       = make_result(KIND_QUEUE_OK, r_item.seq_no, r_item.user_id,
                                          r_item.obj_idx, r_item.lk_type,
                                          r_item.cont_cnt, 4'd0, 8'd0,
                                          r_mgr_id, 1'b1);
                if (w_out_free || !w_rr_ok) begin
                    w_mem_we = 1'b1;
                    w_emit   = w_rr_ok;
                    n_state  = ST_IDLE;
                end
            end
            ST_GRANT: begin
                if (w_scan.done) begin
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (w_scan.grant_vld) begin
                    w_res = make_result(KIND_GRANT, r_item.seq_no, 32'd0, r_item.obj_idx,
                                        w_scan.gtype, 16'd0, w_scan.node[3:0],
                                        r_owner_id, r_mgr_id, 1'b0);
                    if (w_out_free) begin
                        w_emit      = 1'b1;
                        w_scan_step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_bit <= 32'd1;
            r_owner_id  <= 8'd0;
            r_mgr_id    <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OWNER_BIT: r_owner_bit <= i_cfg_data;
                CFG_OWNER_ID:  r_owner_id  <= i_cfg_data[7:0];
                CFG_MGR_ID:    r_mgr_id    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    `BVRW_ASSERT_NXT(a_accept_to_addr, i_clk, i_rst_n, w_accept, r_state == ST_ADDR)
    `BVRW_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, w_emit && w_res.last, r_state == ST_IDLE)
    `BVRW_ASSERT_IMP(a_wr_slot, i_clk, i_rst_n, w_mem_we && (r_state != ST_CLEAR), w_mem_waddr == w_slot)

endmodule

FILE: verif/tb_bitvector_rw_lock_resolver.sv
// Self-checking testbench for bitvector_rw_lock_resolver: directed and random completions.
module tb_bitvector_rw_lock_resolver;
    timeunit 1ns;
    timeprecision 1ps;

    import bvrw_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int NODE_COUNT    = 16;
    localparam int GRANT_CAP     = 32;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_OWNER_BIT;
    logic [31:0] i_cfg_data  = '0;

    logic [63:0] waiter_words [1024];
    logic [31:0] mdl_owner_bit = 32'd1;
    logic [7:0]  mdl_owner_id  = 8'd0;
    logic [7:0]  mdl_mgr_id    = 8'd0;
    t_out_item   owed_results[$];

    int err_count   = 0;
    int cycle_count = 0;
    int out_stall   = 0;
    bit idle_en     = 1'b1;

    bitvector_rw_lock_resolver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[bitvector_rw_lock_resolver] ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            out_stall = $urandom_range(1, 5) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [63:0] byte_swap64(input logic [63:0] w);
        logic [63:0] r;
        r = {<<8{w}};
        return r;
    endfunction

    function automatic void owe(input logic [2:0] kind, input logic [31:0] seq,
                                input logic [31:0] user, input logic [9:0] obj,
                                input logic ltype, input logic [15:0] cont,
                                input logic [3:0] node, input logic [7:0] own,
                                input logic last);
        t_out_item r;
        r.kind           = kind;
        r.res_seq_no     = seq;
        r.res_user_id    = user;
        r.res_obj_idx    = obj;
        r.res_lk_type    = ltype;
        r.res_contention = cont;
        r.grant_node     = node;
        r.res_owner_id   = own;
        r.res_mgr_id     = mdl_mgr_id;
        r.last           = last;
        owed_results.push_back(r);
    endfunction

    function automatic int grant_nodes(input int k, input logic [31:0] bits,
                                       input logic gtype, input t_in_item it);
        for (int pos = 0; pos < NODE_COUNT; pos++) begin
            if (k >= GRANT_CAP)
                break;
            if (bits[pos]) begin
                owe(KIND_GRANT, it.seq_no, '0, it.obj_idx, gtype, '0, 4'(pos),
                    mdl_owner_id, 1'b0);
                k++;
            end
        end
        return k;
    endfunction

    function automatic void resolve_completion(input t_in_item it);
        logic [63:0] v;
        logic [63:0] rem;
        logic [31:0] ex;
        logic [31:0] sh;
        logic [15:0] cnt;
        int          k;
        v   = byte_swap64(it.lock_word);
        ex  = v[63:32];
        sh  = v[31:0];
        cnt = it.cont_cnt;
        k   = 0;
        case (it.func)
            FUNC_LOCK: begin
                if (it.lk_type ? (v == '0) : (ex == '0)) begin
                    owe(KIND_LOCK_OK, it.seq_no, it.user_id, it.obj_idx, it.lk_type,
                        cnt, '0, '0, 1'b1);
                end else begin
                    waiter_words[it.obj_idx] = v;
                    if (cnt != 16'hFFFF)
                        cnt++;
                    owe(KIND_QUEUED, it.seq_no, it.user_id, it.obj_idx, it.lk_type,
                        cnt, '0, '0, 1'b1);
                end
            end
            FUNC_UNLOCK: begin
                if (!it.undo) begin
                    if (it.lk_type)
                        ex = ex - mdl_owner_bit;
                    else
                        sh = sh - mdl_owner_bit;
                    if (!it.lk_type) begin
                        k = grant_nodes(k, ex, 1'b1, it);
                    end else begin
                        k = grant_nodes(k, sh, 1'b0, it);
                        k = grant_nodes(k, ex, 1'b1, it);
                    end
                    owe(KIND_UNLOCK_OK, it.seq_no, it.user_id, it.obj_idx, it.lk_type,
                        cnt, '0, '0, 1'b1);
                end
            end
            FUNC_REREAD: begin
                waiter_words[it.obj_idx][it.rel_node]      = 1'b0;
                waiter_words[it.obj_idx][32 + it.rel_node] = 1'b0;
                rem = it.lock_word & waiter_words[it.obj_idx];
                if (rem == '0 || (rem[63:32] == '0 && !it.lk_type))
                    owe(KIND_QUEUE_OK, it.seq_no, it.user_id, it.obj_idx, it.lk_type,
                        cnt, '0, '0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] expv,
                                        input logic [63:0] actv);
        if (actv !== expv) begin
            err_count++;
            $error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (owed_results.size() == 0) begin
                err_count++;
                $error("unexpected result transfer, kind %0h", o_out_data.kind);
            end else begin
                want = owed_results.pop_front();
                check_field("kind", want.kind, o_out_data.kind);
                check_field("res_seq_no", want.res_seq_no, o_out_data.res_seq_no);
                check_field("res_user_id", want.res_user_id, o_out_data.res_user_id);
                check_field("res_obj_idx", want.res_obj_idx, o_out_data.res_obj_idx);
                check_field("res_lk_type", want.res_lk_type, o_out_data.res_lk_type);
                check_field("res_contention", want.res_contention,
                            o_out_data.res_contention);
                check_field("grant_node", want.grant_node, o_out_data.grant_node);
                check_field("res_owner_id", want.res_owner_id, o_out_data.res_owner_id);
                check_field("res_mgr_id", want.res_mgr_id, o_out_data.res_mgr_id);
                check_field("last", want.last, o_out_data.last);
            end
        end
    end

    function automatic t_in_item mk_item(input logic [1:0] func, input logic [9:0] obj,
                                         input logic ltype, input logic [63:0] word,
                                         input logic [3:0] rel, input logic [31:0] seq,
                                         input logic [31:0] user, input logic [15:0] cont,
                                         input logic undo);
        t_in_item it;
        it.func      = func;
        it.obj_idx   = obj;
        it.lk_type   = ltype;
        it.lock_word = word;
        it.rel_node  = rel;
        it.seq_no    = seq;
        it.user_id   = user;
        it.cont_cnt  = cont;
        it.undo      = undo;
        return it;
    endfunction

    function automatic logic [31:0] rand_half();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return '0;
        else if (r < 8)
            return {16'h0, 16'($urandom & $urandom)};
        else if (r == 8)
            return $urandom;
        else
            return 32'hFFFF_FFFF;
    endfunction

    function automatic t_in_item rand_completion();
        t_in_item    it;
        int          r;
        logic [31:0] ex;
        logic [31:0] sh;
        it.seq_no   = $urandom;
        it.user_id  = $urandom;
        it.cont_cnt = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
        it.obj_idx  = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                  : 10'($urandom_range(0, 7));
        it.lk_type  = 1'($urandom_range(0, 1));
        it.rel_node = 4'($urandom_range(0, 15));
        it.undo     = 1'b0;
        ex = rand_half();
        sh = rand_half();
        r  = $urandom_range(0, 99);
        if (r < 38) begin
            it.func      = FUNC_LOCK;
            it.lock_word = byte_swap64({ex, sh});
        end else if (r < 68) begin
            it.func = FUNC_UNLOCK;
            it.undo = ($urandom_range(0, 9) == 0);
            if (it.lk_type)
                ex = ex | mdl_owner_bit;
            else
                sh = sh | mdl_owner_bit;
            it.lock_word = byte_swap64({ex, sh});
        end else if (r < 95) begin
            it.func      = FUNC_REREAD;
            it.lock_word = {ex, sh};
        end else begin
            it.func      = FUNC_UNUSED;
            it.lock_word = {$urandom, $urandom};
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        resolve_completion(it);
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [31:0] owner_bit, input logic [7:0] owner_id,
                                input logic [7:0] mgr_id);
        logic [1:0]  idx  [3];
        logic [31:0] vals [3];
        idx  = '{CFG_OWNER_BIT, CFG_OWNER_ID, CFG_MGR_ID};
        vals = '{owner_bit, {24'h0, owner_id}, {24'h0, mgr_id}};
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            case (idx[i])
                CFG_OWNER_BIT: mdl_owner_bit = vals[i];
                CFG_OWNER_ID:  mdl_owner_id  = vals[i][7:0];
                CFG_MGR_ID:    mdl_mgr_id    = vals[i][7:0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_lock_paths();
        send_item(mk_item(FUNC_LOCK, 10'd1, 1'b0, byte_swap64({32'h0, 32'hFFFF_FFFF}),
                          4'd0, 32'd0, 32'd0, 16'd0, 1'b0));
        send_item(mk_item(FUNC_LOCK, 10'd1023, 1'b1, 64'h0, 4'd15, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        send_item(mk_item(FUNC_LOCK, 10'd5, 1'b1, byte_swap64({32'h0, 32'h8}),
                          4'd0, $urandom, $urandom, 16'd0, 1'b0));
        send_item(mk_item(FUNC_LOCK, 10'd6, 1'b0, byte_swap64({32'h0010_0080, 32'h0}),
                          4'd0, $urandom, $urandom, 16'hFFFF, 1'b0));
        send_item(mk_item(FUNC_LOCK, 10'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                          4'd0, $urandom, $urandom, 16'h7FFE, 1'b0));
    endtask

    task automatic test_reread_paths();
        send_item(mk_item(FUNC_REREAD, 10'd5, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd3,
                          $urandom, $urandom, 16'd1, 1'b0));
        send_item(mk_item(FUNC_REREAD, 10'd6, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,
                          $urandom, $urandom, 16'd2, 1'b0));
        send_item(mk_item(FUNC_REREAD, 10'd6, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd7,
                          $urandom, $urandom, 16'd3, 1'b0));
        send_item(mk_item(FUNC_REREAD, 10'd6, 1'b0, 64'h0000_FFFF_FFFF_FFFF, 4'd7,
                          $urandom, $urandom, 16'd4, 1'b0));
        send_item(mk_item(FUNC_REREAD, 10'd100, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9,
                          $urandom, $urandom, 16'd5, 1'b0));
        send_item(mk_item(FUNC_REREAD, 10'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15,
                          $urandom, $urandom, 16'd6, 1'b0));
    endtask

    task automatic test_unlock_paths();
        send_item(mk_item(FUNC_UNLOCK, 10'd2, 1'b0, byte_swap64({32'h0000_00A5, 32'h1}),
                          4'd0, $urandom, $urandom, 16'($urandom), 1'b0));
        send_item(mk_item(FUNC_UNLOCK, 10'd3, 1'b1, byte_swap64({32'h1, 32'hFFFF_0003}),
                          4'd0, $urandom, $urandom, 16'($urandom), 1'b0));
    endtask

    task automatic test_ignored_items();
        send_item(mk_item(FUNC_UNLOCK, 10'd4, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,
                          $urandom, $urandom, 16'($urandom), 1'b1));
        send_item(mk_item(FUNC_UNUSED, 10'd4, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,
                          $urandom, $urandom, 16'($urandom), 1'b0));
    endtask

    task automatic test_grant_limits();
        settle_block();
        write_config(32'h0, 8'hFF, 8'hFF);
        send_item(mk_item(FUNC_UNLOCK, 10'd7, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,
                          $urandom, $urandom, 16'($urandom), 1'b0));
        send_item(mk_item(FUNC_UNLOCK, 10'd7, 1'b0, 64'h0, 4'd0,
                          $urandom, $urandom, 16'($urandom), 1'b0));
        settle_block();
        write_config(32'hFFFF_FFFF, 8'h5A, 8'hA5);
        send_item(mk_item(FUNC_UNLOCK, 10'd8, 1'b1, byte_swap64({32'hFFFF_FFFF, 32'h8000}),
                          4'd0, $urandom, $urandom, 16'($urandom), 1'b0));
        send_item(mk_item(FUNC_UNLOCK, 10'd8, 1'b0, byte_swap64({32'h0000_FFFF, 32'h0}),
                          4'd0, $urandom, $urandom, 16'($urandom), 1'b0));
        send_item(mk_item(FUNC_LOCK, 10'd9, 1'b0, 64'h0, 4'd0,
                          $urandom, $urandom, 16'($urandom), 1'b0));
    endtask

    task automatic test_random_traffic(input int count, input int pause_at);
        for (int n = 0; n < count; n++) begin
            if (n == pause_at)
                settle_block();
            send_item(rand_completion());
        end
    endtask

    initial begin
        for (int i = 0; i < 1024; i++)
            waiter_words[i] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_lock_paths();
        test_reread_paths();
        test_unlock_paths();
        test_ignored_items();
        test_grant_limits();

        settle_block();
        write_config(32'd1 << $urandom_range(0, 15), 8'($urandom), 8'($urandom));
        test_random_traffic(90, 45);

        settle_block();
        write_config($urandom, 8'($urandom), 8'($urandom));
        test_random_traffic(80, -1);

        settle_block();
        write_config(32'd1 << $urandom_range(0, 15), 8'($urandom), 8'($urandom));
        idle_en = 1'b0;
        test_random_traffic(80, -1);

        settle_block();
        if (err_count == 0)
            $display("[bitvector_rw_lock_resolver] OK");
        else
            $display("[bitvector_rw_lock_resolver] ERROR");
        $finish;
    end

endmodule

FILE: bitvector_rw_lock_resolver.f
+incdir+rtl
rtl/bvrw_pkg.sv
rtl/bvrw_mem.sv
rtl/bvrw_slot.sv
rtl/bvrw_scan.sv
rtl/bitvector_rw_lock_resolver.sv
verif/tb_bitvector_rw_lock_resolver.sv
